// ----- sv/smtag_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shear mirror tile address generator package
// Widths, register indexes and pipeline lane types shared by the block.
// ----------------------------------------------------------------------------
package smtag_pkg;

    localparam int CoordW   = 12;
    localparam int BoundW   = 13;
    localparam int CoeffW   = 16;
    localparam int PeriodW  = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam int DiffW  = CoordW + 1;
    localparam int FracW  = 12;
    localparam int ProdW  = CoeffW + DiffW;
    localparam int SumW   = ProdW;
    localparam int MagW   = SumW - 1;
    localparam int LowW   = FracW - 3;
    localparam int QuoW   = MagW - LowW;
    localparam int RemW   = PeriodW + 1;
    localparam int ModW   = PeriodW + LowW;
    localparam int RoundW = ModW - FracW;
    localparam int Lanes  = 2;

    localparam logic [CfgIdxW-1:0] RegShearX  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegShearY  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegPeriod  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCenterC = 3'd3;
    localparam logic [CfgIdxW-1:0] RegCenterR = 3'd4;
    localparam logic [CfgIdxW-1:0] RegImgCols = 3'd5;
    localparam logic [CfgIdxW-1:0] RegImgRows = 3'd6;

    typedef struct packed {
        logic signed [DiffW-1:0] diff;
        logic signed [ProdW-1:0] prod;
    } mul_lane_t;

    typedef struct packed {
        logic                neg;
        logic [QuoW-1:0]     num;
        logic [LowW-1:0]     low;
        logic [PeriodW-1:0]  rem;
    } div_lane_t;

endpackage

// ----- sv/smtag_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shear mirror tile address generator channels
// Valid/ready channels for pixel coordinates in, source coordinates out and
// configuration writes.
// ----------------------------------------------------------------------------
interface smtag_pix_in_if;
    logic                            valid;
    logic                            ready;
    logic [smtag_pkg::CoordW-1:0]    out_col;
    logic [smtag_pkg::CoordW-1:0]    out_row;

    modport source (output valid, output out_col, output out_row, input ready);
    modport sink (input valid, input out_col, input out_row, output ready);
endinterface

interface smtag_pix_out_if;
    logic                            valid;
    logic                            ready;
    logic [smtag_pkg::CoordW-1:0]    src_col;
    logic [smtag_pkg::CoordW-1:0]    src_row;

    modport source (output valid, output src_col, output src_row, input ready);
    modport sink (input valid, input src_col, input src_row, output ready);
endinterface

interface smtag_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [smtag_pkg::CfgIdxW-1:0]   index;
    logic [smtag_pkg::CfgDataW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/shear_mirror_tile_address_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shear mirror tile address generator
// Maps an output pixel coordinate to the source pixel to fetch.
// ----------------------------------------------------------------------------
// The pix_in channel takes one output pixel coordinate per beat and the
// pix_out channel returns one clamped source coordinate per beat, in order.
// The cfg channel writes the seven setup registers by index and is always
// ready; the user must write it only while no beat is in flight (unchecked).
// The datapath is a 24 stage pipeline: a multiply stage, a sum and magnitude
// stage, one stage per quotient bit of the 19 step remainder unit that reduces
// the sheared coordinate modulo twice the tile period, a sign fixup stage, a
// mirror fold stage and a round and clamp stage that feeds the output register.
// One beat
// per cycle is accepted while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and pix_in.ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the default register values.
// ----------------------------------------------------------------------------
module shear_mirror_tile_address_gen #(
    parameter int MAX_DIM = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    smtag_pix_in_if.sink    pix_in,
    smtag_pix_out_if.source pix_out,
    smtag_cfg_if.sink       cfg
);

    localparam int Lanes  = smtag_pkg::Lanes;
    localparam int QuoW   = smtag_pkg::QuoW;
    localparam int ModW   = smtag_pkg::ModW;
    localparam int LowW   = smtag_pkg::LowW;
    localparam int PerW   = smtag_pkg::PeriodW;
    localparam int RndW   = smtag_pkg::RoundW;
    localparam int NumSt  = QuoW + 5;
    localparam int DimW   = $clog2(MAX_DIM + 1);
    localparam int CmpW   = (DimW > smtag_pkg::BoundW) ? DimW : smtag_pkg::BoundW;

    logic signed [smtag_pkg::CoeffW-1:0]  shear_x_reg;
    logic signed [smtag_pkg::CoeffW-1:0]  shear_y_reg;
    logic [PerW-1:0]                      period_reg;
    logic [smtag_pkg::CoordW-1:0]         center_col_reg;
    logic [smtag_pkg::CoordW-1:0]         center_row_reg;
    logic [smtag_pkg::BoundW-1:0]         image_cols_reg;
    logic [smtag_pkg::BoundW-1:0]         image_rows_reg;

    logic [NumSt-1:0]          vld_reg;
    logic [NumSt-1:0]          vld_next;
    logic                      en;

    smtag_pkg::mul_lane_t      mul_reg  [Lanes];
    smtag_pkg::mul_lane_t      mul_next [Lanes];
    smtag_pkg::div_lane_t      div_reg  [QuoW+1][Lanes];
    smtag_pkg::div_lane_t      div_next [QuoW+1][Lanes];
    logic [ModW-1:0]           fix_reg  [Lanes];
    logic [ModW-1:0]           fix_next [Lanes];
    logic [ModW-1:0]           fold_reg [Lanes];
    logic [ModW-1:0]           fold_next[Lanes];
    logic [smtag_pkg::CoordW-1:0] out_reg [Lanes];
    logic [smtag_pkg::CoordW-1:0] out_next[Lanes];

    logic signed [smtag_pkg::CoeffW-1:0]  coeff [Lanes];
    logic signed [smtag_pkg::DiffW-1:0]   diff  [Lanes];
    logic [smtag_pkg::BoundW-1:0]         bound [Lanes];
    logic [ModW-1:0]                      two_p;
    logic [ModW-1:0]                      one_p;

    assign en           = !vld_reg[NumSt-1] || pix_out.ready;
    assign pix_in.ready = en;
    assign cfg.ready    = 1'b1;

    assign pix_out.valid   = vld_reg[NumSt-1];
    assign pix_out.src_col = out_reg[0];
    assign pix_out.src_row = out_reg[1];

    assign coeff[0] = shear_x_reg;
    assign coeff[1] = shear_y_reg;
    assign diff[0]  = $signed({1'b0, pix_in.out_col}) - $signed({1'b0, center_col_reg});
    assign diff[1]  = $signed({1'b0, pix_in.out_row}) - $signed({1'b0, center_row_reg});
    assign bound[0] = image_cols_reg;
    assign bound[1] = image_rows_reg;
    assign two_p    = {period_reg, {LowW{1'b0}}};
    assign one_p    = {1'b0, period_reg, {(LowW-1){1'b0}}};

    always_comb
    begin
        logic signed [smtag_pkg::SumW-1:0] sum;
        logic [smtag_pkg::SumW-1:0]        mag;
        logic [smtag_pkg::RemW-1:0]        rsh;
        logic [ModW-1:0]                   m;
        logic [ModW-1:0]                   rnd;
        logic [RndW-1:0]                   v;
        logic [CmpW-1:0]                   lim;
        logic [CmpW-1:0]                   hi;
        logic [CmpW-1:0]                   res;

        vld_next = {vld_reg[NumSt-2:0], pix_in.valid};

        for (int l = 0; l < Lanes; l++)
        begin
            mul_next[l].diff = diff[l];
            mul_next[l].prod = smtag_pkg::ProdW'(coeff[l])
                             * smtag_pkg::ProdW'(diff[Lanes-1-l]);

            sum = (smtag_pkg::SumW'(mul_reg[l].diff) <<< smtag_pkg::FracW) + mul_reg[l].prod;
            mag = sum[smtag_pkg::SumW-1] ? smtag_pkg::SumW'(-sum) : smtag_pkg::SumW'(sum);
            div_next[0][l].neg = sum[smtag_pkg::SumW-1];
            div_next[0][l].num = mag[smtag_pkg::MagW-1:LowW];
            div_next[0][l].low = mag[LowW-1:0];
            div_next[0][l].rem = '0;

            for (int k = 0; k < QuoW; k++)
            begin
                rsh = {div_reg[k][l].rem, div_reg[k][l].num[QuoW-1]};
                if (rsh >= {1'b0, period_reg})
                begin
                    rsh = rsh - {1'b0, period_reg};
                end
                div_next[k+1][l].neg = div_reg[k][l].neg;
                div_next[k+1][l].num = {div_reg[k][l].num[QuoW-2:0], 1'b0};
                div_next[k+1][l].low = div_reg[k][l].low;
                div_next[k+1][l].rem = rsh[PerW-1:0];
            end

            m = {div_reg[QuoW][l].rem, div_reg[QuoW][l].low};
            fix_next[l] = (div_reg[QuoW][l].neg && (m != '0)) ? two_p - m : m;

            fold_next[l] = (fix_reg[l] > one_p) ? two_p - fix_reg[l] : fix_reg[l];

            rnd = fold_reg[l] + ModW'(2048);
            v   = (period_reg == '0) ? '0 : rnd[ModW-1:smtag_pkg::FracW];
            lim = (bound[l] == '0) ? CmpW'(1) : CmpW'(bound[l]);
            if (lim > CmpW'(MAX_DIM))
            begin
                lim = CmpW'(MAX_DIM);
            end
            hi  = lim - CmpW'(1);
            res = (CmpW'(v) > hi) ? hi : CmpW'(v);
            out_next[l] = res[smtag_pkg::CoordW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shear_x_reg    <= '0;
            shear_y_reg    <= '0;
            period_reg     <= PerW'(1024);
            center_col_reg <= '0;
            center_row_reg <= '0;
            image_cols_reg <= smtag_pkg::BoundW'(640);
            image_rows_reg <= smtag_pkg::BoundW'(480);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                smtag_pkg::RegShearX:  shear_x_reg    <= cfg.data;
                smtag_pkg::RegShearY:  shear_y_reg    <= cfg.data;
                smtag_pkg::RegPeriod:  period_reg     <= cfg.data;
                smtag_pkg::RegCenterC: center_col_reg <= cfg.data[smtag_pkg::CoordW-1:0];
                smtag_pkg::RegCenterR: center_row_reg <= cfg.data[smtag_pkg::CoordW-1:0];
                smtag_pkg::RegImgCols: image_cols_reg <= cfg.data[smtag_pkg::BoundW-1:0];
                smtag_pkg::RegImgRows: image_rows_reg <= cfg.data[smtag_pkg::BoundW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg  <= mul_next;
            div_reg  <= div_next;
            fix_reg  <= fix_next;
            fold_reg <= fold_next;
            out_reg  <= out_next;
        end
    end

endmodule

// ----- tb/shear_mirror_tile_address_gen_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shear mirror tile address generator testbench
// Writes the setup registers while the pipeline is empty, then streams pixel
// coordinates through it. Each accepted source coordinate beat is compared
// with a fixed point prediction of the shear, fold, round and clamp steps.
// Both channels idle at random, and one long output stall backs the pipeline up.
// ----------------------------------------------------------------------------
module shear_mirror_tile_address_gen_tb;

    localparam int MaxDim = 4096;
    localparam int CycleLimit = 200000;
    localparam int StallCycles = 300;
    localparam int DrainCycles = 40;
    localparam logic [smtag_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

    typedef struct packed {
        logic [smtag_pkg::CoordW-1:0] col;
        logic [smtag_pkg::CoordW-1:0] row;
    } coord_t;

    logic clk;
    logic rst_n;

    smtag_pix_in_if  pix_in_ch ();
    smtag_pix_out_if pix_out_ch ();
    smtag_cfg_if     cfg_ch ();

    shear_mirror_tile_address_gen #(
        .MAX_DIM(MaxDim)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_in (pix_in_ch),
        .pix_out(pix_out_ch),
        .cfg    (cfg_ch)
    );

    logic signed [smtag_pkg::CoeffW-1:0]  kx_q12    = '0;
    logic signed [smtag_pkg::CoeffW-1:0]  ky_q12    = '0;
    logic        [smtag_pkg::PeriodW-1:0] period_q4 = 16'd1024;
    logic        [smtag_pkg::CoordW-1:0]  ctr_col   = '0;
    logic        [smtag_pkg::CoordW-1:0]  ctr_row   = '0;
    logic        [smtag_pkg::BoundW-1:0]  img_cols  = 13'd640;
    logic        [smtag_pkg::BoundW-1:0]  img_rows  = 13'd480;

    coord_t pixel_q[$];
    coord_t src_q[$];
    logic   in_taken = 1'b0;
    int     cfg_beats = 0;
    int     fail_count = 0;
    int     cycle_cnt = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     stall_cnt = 0;
    logic   stall_start = 1'b0;

    function automatic longint fold_tile(longint q12);
        longint p;
        longint d;
        longint r;
        if (period_q4 == 0)
            return 0;
        p = longint'(period_q4) <<< 8;
        d = 2 * p;
        r = q12 % d;
        if (r < 0)
            r += d;
        if (r > p)
            r = d - r;
        return (r + 2048) >>> 12;
    endfunction

    function automatic logic [smtag_pkg::CoordW-1:0] clamp_dim(longint v,
                                                     logic [smtag_pkg::BoundW-1:0] bound);
        longint b;
        b = longint'(bound);
        if (b == 0)
            b = 1;
        if (b > MaxDim)
            b = MaxDim;
        if (v < 0)
            v = 0;
        if (v > b - 1)
            v = b - 1;
        return v[smtag_pkg::CoordW-1:0];
    endfunction

    function automatic coord_t src_coord(logic [smtag_pkg::CoordW-1:0] col,
                                         logic [smtag_pkg::CoordW-1:0] row);
        longint dx;
        longint dy;
        longint sx;
        longint sy;
        coord_t res;
        dx = longint'(col) - longint'(ctr_col);
        dy = longint'(row) - longint'(ctr_row);
        sx = dx * 4096 + longint'(kx_q12) * dy;
        sy = dy * 4096 + longint'(ky_q12) * dx;
        res.col = clamp_dim(fold_tile(sx), img_cols);
        res.row = clamp_dim(fold_tile(sy), img_rows);
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (cfg_ch.valid && cfg_ch.ready)
        begin
            cfg_beats <= cfg_beats + 1;
            case (cfg_ch.index)
                smtag_pkg::RegShearX:  kx_q12    <= cfg_ch.data;
                smtag_pkg::RegShearY:  ky_q12    <= cfg_ch.data;
                smtag_pkg::RegPeriod:  period_q4 <= cfg_ch.data;
                smtag_pkg::RegCenterC: ctr_col   <= cfg_ch.data[smtag_pkg::CoordW-1:0];
                smtag_pkg::RegCenterR: ctr_row   <= cfg_ch.data[smtag_pkg::CoordW-1:0];
                smtag_pkg::RegImgCols: img_cols  <= cfg_ch.data[smtag_pkg::BoundW-1:0];
                smtag_pkg::RegImgRows: img_rows  <= cfg_ch.data[smtag_pkg::BoundW-1:0];
                default: ;
            endcase
        end
    end

    // The pixel at the head of the queue stays on the channel until its beat.
    always @(negedge clk)
    begin
        if (in_taken)
            void'(pixel_q.pop_front());
        if (pix_in_ch.valid && !in_taken)
        begin
        end
        else if (pixel_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
        begin
            pix_in_ch.valid   <= 1'b1;
            pix_in_ch.out_col <= pixel_q[0].col;
            pix_in_ch.out_row <= pixel_q[0].row;
        end
        else
        begin
            pix_in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_start)
            stall_cnt <= StallCycles;
        else if (stall_cnt != 0)
            stall_cnt <= stall_cnt - 1;
    end

    always @(negedge clk)
    begin
        pix_out_ch.ready <= (stall_cnt == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        coord_t want;
        in_taken <= pix_in_ch.valid && pix_in_ch.ready;
        if (pix_in_ch.valid && pix_in_ch.ready)
            src_q.push_back(src_coord(pix_in_ch.out_col, pix_in_ch.out_row));
        if (pix_out_ch.valid && pix_out_ch.ready)
        begin
            if (src_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got col %0d row %0d",
                         $realtime, pix_out_ch.src_col, pix_out_ch.src_row);
                fail_count++;
            end
            else
            begin
                want = src_q.pop_front();
                if (pix_out_ch.src_col !== want.col)
                begin
                    $display("%0t: src_col mismatch, expected %0d, got %0d",
                             $realtime, want.col, pix_out_ch.src_col);
                    fail_count++;
                end
                if (pix_out_ch.src_row !== want.row)
                begin
                    $display("%0t: src_row mismatch, expected %0d, got %0d",
                             $realtime, want.row, pix_out_ch.src_row);
                    fail_count++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic write_reg(logic [smtag_pkg::CfgIdxW-1:0] idx,
                             logic [smtag_pkg::CfgDataW-1:0] val);
        int seen;
        seen = cfg_beats;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(negedge clk);
        while (cfg_beats == seen)
            @(negedge clk);
    endtask

    task automatic load_regs(logic [15:0] kx, logic [15:0] ky, logic [15:0] per,
                             logic [15:0] cc, logic [15:0] cr,
                             logic [15:0] ic, logic [15:0] ir);
        write_reg(smtag_pkg::RegShearX, kx);
        write_reg(smtag_pkg::RegShearY, ky);
        write_reg(smtag_pkg::RegPeriod, per);
        write_reg(smtag_pkg::RegCenterC, cc);
        write_reg(smtag_pkg::RegCenterR, cr);
        write_reg(smtag_pkg::RegImgCols, ic);
        write_reg(smtag_pkg::RegImgRows, ir);
    endtask

    function automatic logic [15:0] rand_coeff();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 8192)) - 16'd4096;
            2: return 16'd0;
            default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    function automatic logic [15:0] rand_bound();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(1, 4096));
            1: return 16'($urandom_range(0, 65535));
            2: return 16'd4096;
            default: return 16'($urandom_range(0, 64));
        endcase
    endfunction

    task automatic random_regs();
        logic [15:0] per;
        case ($urandom_range(0, 3))
            0: per = 16'($urandom_range(0, 65535));
            1: per = 16'($urandom_range(1, 512));
            2: per = 16'($urandom_range(0, 1));
            default: per = 16'($urandom_range(512, 16384));
        endcase
        load_regs(rand_coeff(), rand_coeff(), per,
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  rand_bound(), rand_bound());
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_px(logic [smtag_pkg::CoordW-1:0] col,
                           logic [smtag_pkg::CoordW-1:0] row);
        pixel_q.push_back(coord_t'{col, row});
    endtask

    task automatic queue_random(int n);
        int i;
        logic [smtag_pkg::CoordW-1:0] c;
        logic [smtag_pkg::CoordW-1:0] r;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                c = ctr_col + 12'($urandom_range(0, 64)) - 12'd32;
                r = ctr_row + 12'($urandom_range(0, 64)) - 12'd32;
            end
            else
            begin
                c = 12'($urandom_range(0, 4095));
                r = 12'($urandom_range(0, 4095));
            end
            push_px(c, r);
        end
    endtask

    // Called at a rising edge; returns at a falling edge with nothing in flight.
    task automatic drain();
        while (pixel_q.size() != 0 || pix_in_ch.valid || src_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int seg;
        int ph;
        pix_in_ch.valid   = 1'b0;
        pix_in_ch.out_col = '0;
        pix_in_ch.out_row = '0;
        pix_out_ch.ready  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        rst_n             = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(posedge clk);
        push_px(12'd0, 12'd0);
        push_px(12'd4095, 12'd4095);
        push_px(12'd0, 12'd4095);
        push_px(12'd4095, 12'd0);
        push_px(12'hAAA, 12'h555);
        push_px(12'h555, 12'hAAA);
        drain();

        load_regs(16'h7FFF, 16'h8000, 16'd1, 16'd4095, 16'd4095, 16'd4096, 16'd1);
        write_reg(RegUnused, 16'hFFFF);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        push_px(12'd0, 12'd0);
        push_px(12'd4095, 12'd4095);
        push_px(12'd2048, 12'd17);
        push_px(12'd4095, 12'd0);
        drain();

        // Zero tile period, zero image width and an oversized image height.
        load_regs(16'h1000, 16'hF000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd8191);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        push_px(12'd100, 12'd200);
        push_px(12'd4095, 12'd4095);
        push_px(12'd0, 12'd4095);
        drain();

        load_regs(16'h0000, 16'h0000, 16'hFFFF, 16'd2048, 16'd2048, 16'd8191, 16'd0);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        push_px(12'd0, 12'd0);
        push_px(12'd4095, 12'd4095);
        push_px(12'd2047, 12'd2049);
        drain();

        // Half shear on a one pixel period lands on exact rounding midpoints.
        load_regs(16'h0800, 16'h0800, 16'd16, 16'd100, 16'd100, 16'd4096, 16'd4096);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        push_px(12'd101, 12'd100);
        push_px(12'd100, 12'd101);
        push_px(12'd0, 12'd0);
        push_px(12'd4095, 12'd4095);
        drain();

        for (seg = 0; seg < 3; seg++)
        begin
            for (ph = 0; ph < 3; ph++)
            begin
                random_regs();
                @(posedge clk);
                tx_idle_pct = (seg == 0) ? 34 : (seg == 1) ? 84 : 0;
                rx_idle_pct = (seg == 0) ? 84 : (seg == 1) ? 34 : 0;
                queue_random(110);
                if (seg == 2 && ph == 0)
                begin
                    stall_start = 1'b1;
                    @(posedge clk);
                    stall_start = 1'b0;
                end
                drain();
            end
        end

        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
